### hdl/stepper_ramp_profile_generator_macros.svh
// Assertion macros shared by the ramp profile generator modules.
`ifndef STEPPER_RAMP_PROFILE_GENERATOR_MACROS_SVH
`define STEPPER_RAMP_PROFILE_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SRPG_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srpg assertion failed");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SRPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srpg assertion failed");

`endif

### hdl/srpg_pkg.sv
// Types and constants shared by the stepper ramp profile generator.
`default_nettype none

package srpg_pkg;

  // Default full ramp length in steps (acceleration plus deceleration).
  localparam int unsigned RampStepsDef = 128;

  // Configuration port widths and register indexes.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_IDX_STEPS_PER_PIXEL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_BACKLASH_STEPS  = 2'd1;

  // Motion state codes.
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_ACCEL = 2'd1;
  localparam logic [1:0] MODE_MOVE  = 2'd2;
  localparam logic [1:0] MODE_DECEL = 2'd3;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_STOP  = 2'd2
  } req_e;

  // One input word.
  typedef struct packed {
    req_e               req_type;
    logic signed [15:0] move_steps;
    logic               estop;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [1:0]         motion_state;
    logic [5:0]         ramp_index;
    logic signed [15:0] position;
    logic               direction;
    logic               pixel_done;
  } result_t;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0]  steps_per_pixel;
    logic [15:0] backlash_steps;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/srpg_cfg.sv
// Configuration registers: divider reload and backlash step count.
`default_nettype none

module srpg_cfg
  import srpg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output logic                     cfg_ready_o,
  output cfg_t                     cfg_o
);

  logic [7:0]  steps_per_pixel_q;
  logic [15:0] backlash_steps_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register write; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_per_pixel_q <= 8'd1;
      backlash_steps_q  <= 16'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_IDX_STEPS_PER_PIXEL: steps_per_pixel_q <= cfg_data_i[7:0];
        CFG_IDX_BACKLASH_STEPS:  backlash_steps_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.steps_per_pixel = steps_per_pixel_q;
  assign cfg_o.backlash_steps  = backlash_steps_q;

endmodule

`default_nettype wire

### hdl/srpg_engine.sv
// Motion state registers and the single-pass update for one word.
`default_nettype none

module srpg_engine
  import srpg_pkg::*;
#(
  parameter int unsigned RAMP_STEPS = RampStepsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  item_valid_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    result_o
);

  `include "stepper_ramp_profile_generator_macros.svh"

  // Ramp counters hold up to half the ramp length.
  localparam int unsigned RampW = $clog2(RAMP_STEPS / 2 + 1);
  localparam logic [16:0] RampStepsC = 17'(RAMP_STEPS);
  localparam logic [RampW-1:0] RampHalf = RampW'(RAMP_STEPS / 2);

  logic [1:0]       mode_q, mode_d;
  logic             dir_set_q, dir_set_d;
  logic             dir_q, dir_d;
  logic [15:0]      position_q, position_d;
  logic [RampW-1:0] ramp_len_q, ramp_len_d;
  logic [RampW-1:0] ramp_rem_q, ramp_rem_d;
  logic [14:0]      full_rem_q, full_rem_d;
  logic [5:0]       pointer_q, pointer_d;
  logic [7:0]       divider_q, divider_d;
  logic [15:0]      backlash_q, backlash_d;
  logic             done;

  // Start request decode: magnitude, direction and ramp split.
  logic [15:0]      raw;
  logic             start_dir;
  logic [15:0]      mag;
  logic [16:0]      even;
  logic [16:0]      full17;
  logic [RampW-1:0] start_ramp_len;
  logic [14:0]      start_full;

  always_comb begin
    raw            = item_i.move_steps;
    start_dir      = ~raw[15];
    mag            = start_dir ? raw : (~raw + 16'd1);
    even           = {1'b0, mag[15:1], 1'b0};
    full17         = {16'd0, mag[0]} + ((even > RampStepsC) ? (even - RampStepsC) : 17'd0);
    start_ramp_len = (full17 < 17'd2) ? even[RampW:1] : RampHalf;
    start_full     = full17[14:0];
  end

  // Next state for the word in the input register.
  always_comb begin
    mode_d     = mode_q;
    dir_set_d  = dir_set_q;
    dir_d      = dir_q;
    position_d = position_q;
    ramp_len_d = ramp_len_q;
    ramp_rem_d = ramp_rem_q;
    full_rem_d = full_rem_q;
    pointer_d  = pointer_q;
    divider_d  = divider_q;
    backlash_d = backlash_q;
    done       = 1'b0;

    case (item_i.req_type)
      REQ_START: begin
        if (raw != 16'd0) begin
          full_rem_d = start_full;
          ramp_len_d = start_ramp_len;
          ramp_rem_d = start_ramp_len;
          pointer_d  = 6'd0;
          if (!dir_set_q || (dir_q != start_dir)) begin
            backlash_d = cfg_i.backlash_steps;
            dir_set_d  = 1'b1;
            dir_d      = start_dir;
          end
          divider_d = cfg_i.steps_per_pixel;
          if (start_ramp_len != '0) begin
            mode_d = MODE_ACCEL;
          end else begin
            mode_d = (start_full == 15'd1) ? MODE_DECEL : MODE_MOVE;
          end
        end
      end
      REQ_TICK: begin
        if (mode_q != MODE_IDLE) begin
          if (item_i.estop) begin
            mode_d = MODE_IDLE;
          end else begin
            divider_d = divider_q - 8'd1;
            // One position unit is finished: walk the ramp profile.
            if ((divider_d == 8'd0) && (backlash_q == 16'd0)) begin
              case (mode_q)
                MODE_ACCEL: begin
                  ramp_rem_d = ramp_rem_q - RampW'(1);
                  if (ramp_rem_d != '0) begin
                    pointer_d = pointer_q + 6'd1;
                  end else begin
                    mode_d     = (full_rem_q == 15'd0) ? MODE_DECEL : MODE_MOVE;
                    ramp_rem_d = ramp_len_q;
                  end
                end
                MODE_MOVE: begin
                  full_rem_d = full_rem_q - 15'd1;
                  if (full_rem_d == 15'd0) begin
                    mode_d = MODE_DECEL;
                  end
                end
                MODE_DECEL: begin
                  if (ramp_rem_q != '0) begin
                    ramp_rem_d = ramp_rem_q - RampW'(1);
                  end
                  if (ramp_rem_d != '0) begin
                    pointer_d = pointer_q - 6'd1;
                  end else begin
                    mode_d = MODE_IDLE;
                  end
                end
                default: ;
              endcase
              position_d = (dir_set_q && dir_q) ? (position_q + 16'd1)
                                                : (position_q - 16'd1);
            end
          end
          if (mode_d == MODE_IDLE) begin
            backlash_d = 16'd0;
          end
          // Divider reload; backlash steps are consumed here without moving.
          if (divider_d == 8'd0) begin
            divider_d = cfg_i.steps_per_pixel;
            if (backlash_d != 16'd0) begin
              backlash_d = backlash_d - 16'd1;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
      REQ_STOP: begin
        mode_d = MODE_IDLE;
      end
      default: ;
    endcase
  end

  // State update, one word per cycle while item_valid_i is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      dir_set_q  <= 1'b0;
      dir_q      <= 1'b0;
      position_q <= 16'd0;
      ramp_len_q <= '0;
      ramp_rem_q <= '0;
      full_rem_q <= 15'd0;
      pointer_q  <= 6'd0;
      divider_q  <= 8'd0;
      backlash_q <= 16'd0;
    end else if (item_valid_i) begin
      mode_q     <= mode_d;
      dir_set_q  <= dir_set_d;
      dir_q      <= dir_d;
      position_q <= position_d;
      ramp_len_q <= ramp_len_d;
      ramp_rem_q <= ramp_rem_d;
      full_rem_q <= full_rem_d;
      pointer_q  <= pointer_d;
      divider_q  <= divider_d;
      backlash_q <= backlash_d;
    end
  end

  // Result seen after this word.
  assign result_o.motion_state = mode_d;
  assign result_o.ramp_index   = pointer_d;
  assign result_o.position     = position_d;
  assign result_o.direction    = dir_set_d & dir_d;
  assign result_o.pixel_done   = done;

  `SRPG_ASSERT_NEXT(a_start_leaves_idle,
      item_valid_i && (item_i.req_type == REQ_START) && (item_i.move_steps != 16'sd0),
      mode_q != MODE_IDLE)
  `SRPG_ASSERT_IMPL(a_done_only_on_tick, result_o.pixel_done, item_i.req_type == REQ_TICK)
  `SRPG_ASSERT_NEXT(a_idle_tick_holds_position,
      item_valid_i && (mode_q == MODE_IDLE) && (item_i.req_type == REQ_TICK),
      $stable(position_q))

endmodule

`default_nettype wire

### hdl/stepper_ramp_profile_generator.sv
// A word accepted on s_axis passes the input register and then the result register, which
// offers its result on m_axis. Throughput: one word per cycle while m_axis does not stall; the
// motion state updates as a word moves from the input register to the result register.
// Reset (rst_ni low, asynchronous): pipeline empty, motion idle, direction
// unset, counters zero, steps_per_pixel 1 and backlash_steps 0.
// Top level: stepper ramp profile generator with backlash compensation.
`default_nettype none

module stepper_ramp_profile_generator
  import srpg_pkg::*;
#(
  parameter int unsigned RAMP_STEPS = RampStepsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input words.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [23:0]         s_axis_tdata,  // move_steps[15:0], estop[16], zero pad
  input  wire logic [1:0]          s_axis_tuser,  // req_type[1:0]
  // Result words.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [31:0]              m_axis_tdata,  // motion_state[1:0], ramp_index[7:2],
                                                  // position[23:8], direction[24],
                                                  // pixel_done[25], zero pad
  // Configuration writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  `include "stepper_ramp_profile_generator_macros.svh"

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_result_q;
  result_t result;
  cfg_t    cfg;
  logic    advance;

  // The input register moves on when the result register is free or drained.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.req_type   <= req_e'(s_axis_tuser);
      in_item_q.move_steps <= s_axis_tdata[15:0];
      in_item_q.estop      <= s_axis_tdata[16];
    end
  end

  srpg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  srpg_engine #(
    .RAMP_STEPS (RAMP_STEPS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (advance),
    .item_i       (in_item_q),
    .cfg_i        (cfg),
    .result_o     (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_result_q.pixel_done, out_result_q.direction,
                          out_result_q.position, out_result_q.ramp_index,
                          out_result_q.motion_state};

  `SRPG_ASSERT_NEXT(a_advance_fills_result, advance, out_valid_q)

endmodule

`default_nettype wire
